>>> rtl/skh_pkg.sv
// ============================================================================
// skh_pkg
// Shared sizes, types and command bundle of the sparse key histogram core.
// ============================================================================
package skh_pkg;

    // Table and field sizes
    localparam int ENTRIES       = 64;
    localparam int KEY_BITS      = 32;
    localparam int COUNT_BITS    = 32;
    localparam int OCC_BITS      = $clog2(ENTRIES + 1);
    localparam int TOTAL_BITS    = 48;
    localparam int WSUM_BITS     = 64;
    localparam int OUT_DATA_BITS = 152;

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OCC_BITS-1:0]   occ_t;
    typedef logic [TOTAL_BITS-1:0] total_t;
    typedef logic [WSUM_BITS-1:0]  wsum_t;

    localparam count_t COUNT_MAX = '1;
    localparam total_t TOTAL_MAX = '1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input transfer
        logic compare;  // match the key against every cell
        logic select;   // reduce the match vector
        logic commit;   // update the table and load the result
    } cmd_t;

    // One result item
    typedef struct packed {
        logic   dropped;
        wsum_t  weighted_total;
        total_t total_hits;
        occ_t   used_buckets;
        count_t key_count;
    } res_t;

endpackage

>>> rtl/skh_ctrl.sv
// ============================================================================
// skh_ctrl
// Sequencer of the histogram core: accept, compare, select, commit, and the
// result channel valid flag.
// ============================================================================
module skh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output skh_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SEL  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Decode commands
    assign cmd.load    = s_tvalid && s_tready;
    assign cmd.compare = (state_reg == ST_CMP);
    assign cmd.select  = (state_reg == ST_SEL);
    assign cmd.commit  = (state_reg == ST_UPD) && out_free;

    // Advance the sequence; hold in update while the result register is full
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_SEL;
            ST_SEL:  state_next = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Raise valid on commit, drop it when the transfer completes
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> rtl/skh_dpath.sv
// ============================================================================
// skh_dpath
// Ordered row of key/count cells with parallel match, shift insert,
// statistics accumulators and the result register.
// ============================================================================
module skh_dpath (
    input  logic          aclk,
    input  logic          aresetn,
    input  skh_pkg::cmd_t cmd,
    input  logic          in_mode,
    input  skh_pkg::key_t in_key,
    output skh_pkg::res_t res
);

    logic                         mode_reg;
    skh_pkg::key_t                key_reg;
    skh_pkg::key_t                key_cell_reg [skh_pkg::ENTRIES];
    skh_pkg::count_t              cnt_cell_reg [skh_pkg::ENTRIES];
    logic [skh_pkg::ENTRIES-1:0]  valid_reg;
    logic [skh_pkg::ENTRIES-1:0]  ge_reg;
    logic [skh_pkg::ENTRIES-1:0]  eq_reg;
    logic                         hit_reg;
    skh_pkg::count_t              sel_cnt_reg;
    skh_pkg::count_t              sel_cnt_next;
    skh_pkg::occ_t                occ_reg;
    skh_pkg::occ_t                occ_next;
    skh_pkg::total_t              total_reg;
    skh_pkg::total_t              total_next;
    skh_pkg::wsum_t               wsum_reg;
    skh_pkg::wsum_t               wsum_next;
    skh_pkg::res_t                res_reg;
    skh_pkg::res_t                res_next;
    logic                         full;
    logic                         inc_en;
    logic                         ins_en;
    logic                         add_en;

    assign res  = res_reg;
    assign full = valid_reg[skh_pkg::ENTRIES-1];

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
        end
    end

    // Match the key in every cell; an empty cell counts as above the key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ge_reg <= '0;
            eq_reg <= '0;
        end else if (cmd.compare) begin
            for (int i = 0; i < skh_pkg::ENTRIES; i++) begin
                ge_reg[i] <= !valid_reg[i] || (key_cell_reg[i] >= key_reg);
                eq_reg[i] <= valid_reg[i] && (key_cell_reg[i] == key_reg);
            end
        end
    end

    // Pick the count of the matching cell
    always_comb begin
        sel_cnt_next = '0;
        for (int i = 0; i < skh_pkg::ENTRIES; i++) begin
            sel_cnt_next = sel_cnt_next | (cnt_cell_reg[i] & {skh_pkg::COUNT_BITS{eq_reg[i]}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.select) begin
            hit_reg <= |eq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.select) begin
            sel_cnt_reg <= sel_cnt_next;
        end
    end

    // Decide the update
    assign inc_en = cmd.commit && !mode_reg && hit_reg && (sel_cnt_reg != skh_pkg::COUNT_MAX);
    assign ins_en = cmd.commit && !mode_reg && !hit_reg && !full;
    assign add_en = inc_en || ins_en;

    // Statistics after this item
    always_comb begin
        occ_next   = ins_en ? occ_reg + skh_pkg::OCC_BITS'(1) : occ_reg;
        total_next = (add_en && (total_reg != skh_pkg::TOTAL_MAX))
                   ? total_reg + skh_pkg::TOTAL_BITS'(1) : total_reg;
        wsum_next  = add_en ? wsum_reg + skh_pkg::WSUM_BITS'(key_reg) : wsum_reg;
    end

    // Build the result item
    always_comb begin
        if (hit_reg) begin
            res_next.key_count = inc_en ? sel_cnt_reg + skh_pkg::COUNT_BITS'(1) : sel_cnt_reg;
        end else begin
            res_next.key_count = ins_en ? skh_pkg::COUNT_BITS'(1) : '0;
        end
        res_next.used_buckets   = occ_next;
        res_next.total_hits     = total_next;
        res_next.weighted_total = wsum_next;
        res_next.dropped        = !mode_reg && !hit_reg && full;
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_reg <= res_next;
        end
    end

    // Control state: fill marks and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            total_reg <= '0;
            wsum_reg  <= '0;
        end else begin
            if (ins_en) begin
                valid_reg <= {valid_reg[skh_pkg::ENTRIES-2:0], 1'b1};
            end
            occ_reg   <= occ_next;
            total_reg <= total_next;
            wsum_reg  <= wsum_next;
        end
    end

    // Cell row: shift up from the insert point, or bump the matching count
    always_ff @(posedge aclk) begin
        if (ins_en) begin
            if (ge_reg[0]) begin
                key_cell_reg[0] <= key_reg;
                cnt_cell_reg[0] <= skh_pkg::COUNT_BITS'(1);
            end
        end else if (inc_en && eq_reg[0]) begin
            cnt_cell_reg[0] <= cnt_cell_reg[0] + skh_pkg::COUNT_BITS'(1);
        end
        for (int i = 1; i < skh_pkg::ENTRIES; i++) begin
            if (ins_en) begin
                if (ge_reg[i-1]) begin
                    key_cell_reg[i] <= key_cell_reg[i-1];
                    cnt_cell_reg[i] <= cnt_cell_reg[i-1];
                end else if (ge_reg[i]) begin
                    key_cell_reg[i] <= key_reg;
                    cnt_cell_reg[i] <= skh_pkg::COUNT_BITS'(1);
                end
            end else if (inc_en && eq_reg[i]) begin
                cnt_cell_reg[i] <= cnt_cell_reg[i] + skh_pkg::COUNT_BITS'(1);
            end
        end
    end

    // Fill count tracks the occupied cells
    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(occ_reg) == $countones(valid_reg))
        else $error("fill count disagrees with occupied cells");

    // Occupied cells form a prefix of the row
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_reg >> 1) & ~valid_reg) == '0)
        else $error("occupied cells are not contiguous");

    // Keys are distinct, so at most one cell matches
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(eq_reg))
        else $error("more than one cell matched the key");

    // An insert grows the table by one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |=> occ_reg == $past(occ_reg) + skh_pkg::OCC_BITS'(1))
        else $error("insert did not grow the table");

endmodule

>>> rtl/sparse_key_histogram_core.sv
// m_tvalid rises after the match, select and commit steps that follow the input
// transfer; commit is held while the previous result waits on m_tready.
// The single match/update sequence over the 64-cell ordered row handles one item
// at a time. The next input is taken while a result waits.
// Reset (aresetn low, synchronous): empties the table and clears all totals at
// once; no clearing pass, so the core accepts items right after reset.
// ============================================================================
// sparse_key_histogram_core
// Bounded ordered key histogram with counting, lookup and running totals.
// ============================================================================
module sparse_key_histogram_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] key
    input  logic [0:0]   s_tuser,   // [0] mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // [31:0] key_count, [38:32] used_buckets,
                                    // [86:39] total_hits, [150:87] weighted_total,
                                    // [151] zero
    output logic [0:0]   m_tuser    // [0] dropped
);

    skh_pkg::cmd_t cmd;
    skh_pkg::res_t res;

    skh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    skh_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_mode (s_tuser[0]),
        .in_key  (s_tdata[skh_pkg::KEY_BITS-1:0]),
        .res     (res)
    );

    // Pack the result fields, lowest first
    assign m_tdata = skh_pkg::OUT_DATA_BITS'({res.weighted_total, res.total_hits,
                                              res.used_buckets, res.key_count});
    assign m_tuser = res.dropped;

endmodule
